### sv/vlud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlud_pkg
// shared types, constants and status codes for the variable-length decoder
// ----------------------------------------------------------------------------
package vlud_pkg;

    localparam int unsigned MAX_ZERO_BYTES = 2;
    localparam int unsigned VALUE_WIDTH    = 64;

    localparam logic [63:0] VALUE_MASK =
        (VALUE_WIDTH >= 64) ? ~64'd0 : ((64'd1 << (VALUE_WIDTH % 64)) - 64'd1);

    localparam logic [1:0] MAX_ZEROS = 2'(MAX_ZERO_BYTES);
    localparam logic [4:0] GROUP_BYTES = 5'd7;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EOS      = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic        in_body;
        logic [1:0]  zero_cnt;
        logic [4:0]  remaining;
        logic [63:0] acc;
        logic [4:0]  count;
    } dec_state_t;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        logic [4:0]  used;
    } result_t;

endpackage

### sv/vlud_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlud_byte_if
// input channel: one coded byte or an end-of-stream mark per transfer
// ----------------------------------------------------------------------------
interface vlud_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### sv/vlud_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlud_result_if
// output channel: one decoded number with status per transfer
// ----------------------------------------------------------------------------
interface vlud_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] decoded_value;
    logic [1:0]  status;
    logic [4:0]  bytes_used;

    modport source (output valid, output decoded_value, output status,
                    output bytes_used, input ready);
    modport sink   (input valid, input decoded_value, input status,
                    input bytes_used, output ready);
endinterface

### sv/vlud_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlud_step
// next-state and result logic for one byte of the coded stream
// ----------------------------------------------------------------------------
module vlud_step
(
    input  vlud_pkg::dec_state_t state,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_stream,
    output vlud_pkg::dec_state_t state_next,
    output logic                 has_result,
    output vlud_pkg::result_t    result
);

    logic [5:0] used_wide;
    logic [4:0] used_sat;
    logic [2:0] marker_pos;
    logic [7:0] low_mask;
    logic [4:0] first_remaining;
    logic [63:0] marker_acc;
    logic [63:0] body_acc;
    logic [4:0] body_remaining;

    // position of highest set bit, zero for a zero byte
    function automatic logic [2:0] top_bit(input logic [7:0] b);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (b[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

    assign used_wide       = {1'b0, state.count} + 6'd1;
    assign used_sat        = used_wide[5] ? 5'd31 : used_wide[4:0];
    assign marker_pos      = top_bit(data_byte);
    assign low_mask        = ~(8'hFF << marker_pos);
    assign first_remaining = (5'd7 - {2'b00, marker_pos})
                           + vlud_pkg::GROUP_BYTES * {3'b000, state.zero_cnt};
    assign marker_acc      = {56'd0, data_byte & low_mask} & vlud_pkg::VALUE_MASK;
    assign body_acc        = {state.acc[55:0], data_byte} & vlud_pkg::VALUE_MASK;
    assign body_remaining  = state.remaining - 5'd1;

    always_comb
    begin
        state_next    = state;
        has_result    = 1'b0;
        result.value  = 64'd0;
        result.status = vlud_pkg::STATUS_OK;
        result.used   = used_sat;

        if (end_of_stream)
        begin
            has_result    = 1'b1;
            result.status = vlud_pkg::STATUS_EOS;
            result.used   = state.count;
        end
        else if (!state.in_body)
        begin
            if (data_byte == 8'h00)
            begin
                if (state.zero_cnt >= vlud_pkg::MAX_ZEROS)
                begin
                    has_result    = 1'b1;
                    result.status = vlud_pkg::STATUS_TOO_LONG;
                end
                else
                begin
                    state_next.zero_cnt = state.zero_cnt + 2'd1;
                    state_next.count    = used_wide[4:0];
                end
            end
            else if (first_remaining == 5'd0)
            begin
                has_result   = 1'b1;
                result.value = marker_acc;
            end
            else
            begin
                state_next.in_body   = 1'b1;
                state_next.acc       = marker_acc;
                state_next.remaining = first_remaining;
                state_next.count     = used_sat;
            end
        end
        else
        begin
            state_next.acc       = body_acc;
            state_next.remaining = body_remaining;
            state_next.count     = used_sat;
            if (body_remaining == 5'd0)
            begin
                has_result   = 1'b1;
                result.value = body_acc;
            end
        end

        // every result returns the decoder to idle
        if (has_result)
        begin
            state_next = '0;
        end
    end

endmodule

### sv/vlud_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlud_out_buf
// result register with a skid stage, ready taken straight from a flop
// ----------------------------------------------------------------------------
module vlud_out_buf
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  vlud_pkg::result_t        push_data,
    output logic                     space,
    output logic                     out_valid,
    output vlud_pkg::result_t        out_data,
    input  logic                     out_ready
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    vlud_pkg::result_t out_data_reg;
    vlud_pkg::result_t out_data_next;
    vlud_pkg::result_t skid_data_reg;
    vlud_pkg::result_t skid_data_next;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && out_valid_reg) |-> !skid_valid_reg)
        else $error("result pushed with both stages full");

    a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage did not move into output register");
`endif

endmodule

### sv/variable_length_uint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_length_uint_decoder
// decodes length-prefixed unsigned integers from a byte stream
// ----------------------------------------------------------------------------
// result: the transfer of the byte that completes a number (or of an end-of-stream
//   mark or excess zero byte) is registered into the result register or skid stage
// throughput: one byte per cycle; ready drops only when both the result
//   register and its skid stage hold results not yet taken
// reset: rst_n clears the decoder state and both output stages at once
module variable_length_uint_decoder
(
    input  logic          clk,
    input  logic          rst_n,
    vlud_byte_if.sink     byte_stream,
    vlud_result_if.source result_stream
);

    // decoder state, updated once per accepted byte
    vlud_pkg::dec_state_t state_reg;
    vlud_pkg::dec_state_t state_next;

    logic              accept;
    logic              has_result;
    logic              space;
    logic              res_valid;
    vlud_pkg::result_t result;
    vlud_pkg::result_t res_data;

    // ready comes from the skid flop, so a stalled sink never blocks a byte
    // while a stage is still free
    assign byte_stream.ready = space;
    assign accept            = byte_stream.valid && space;

    // single pass: priority detect, counters and accumulator shift
    vlud_step u_step
    (
        .state         (state_reg),
        .data_byte     (byte_stream.data_byte),
        .end_of_stream (byte_stream.end_of_stream),
        .state_next    (state_next),
        .has_result    (has_result),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result register plus skid stage
    vlud_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && has_result),
        .push_data (result),
        .space     (space),
        .out_valid (res_valid),
        .out_data  (res_data),
        .out_ready (result_stream.ready)
    );

    assign result_stream.valid         = res_valid;
    assign result_stream.decoded_value = res_data.value;
    assign result_stream.status        = res_data.status;
    assign result_stream.bytes_used    = res_data.used;

`ifndef ASSERT_OFF
    // idle decoder has nothing outstanding
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.in_body |-> (state_reg.remaining == 5'd0))
        else $error("bytes outstanding while idle");

    // in the body at least one byte is always still owed
    a_body_owes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_body |-> (state_reg.remaining != 5'd0))
        else $error("body state with no bytes outstanding");

    // an end-of-stream transfer always resets the decoder
    a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_stream.end_of_stream) |=>
            (!state_reg.in_body && state_reg.zero_cnt == 2'd0 && state_reg.count == 5'd0))
        else $error("decoder not idle after end of stream");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.status != vlud_pkg::STATUS_OK) |->
            (res_data.value == 64'd0))
        else $error("error result with nonzero value");
`endif

endmodule
